// File: hw/rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, codes and types of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // pool geometry; BLOCK_BYTES and NUM_BLOCKS are powers of two
    localparam int BLOCK_BYTES = 32;
    localparam int NUM_BLOCKS  = 16;
    localparam int POOL_BYTES  = NUM_BLOCKS * BLOCK_BYTES;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int IDX_W       = $clog2(NUM_BLOCKS);
    localparam int DEPTH_W     = $clog2(NUM_BLOCKS + 1);

    // item field widths
    localparam int OPCODE_W = 2;
    localparam int OFF_IN_W = 10;
    localparam int SIZE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int BOFF_W   = 9;
    localparam int FCOUNT_W = 5;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // operations
    localparam logic [OPCODE_W-1:0] OP_ALLOC       = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC_CHECK = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FREE        = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_REINIT      = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd4;

    // access to the free stack memory
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
        logic             clear;
    } stack_req_t;

endpackage

// File: hw/rtl/fbpa_stack_ram.sv
// ----------------------------------------------------------------------------
// fbpa_stack_ram
// Free stack memory, one read and one write port, registered read data.
// An entry never written since reset or reinit reads as its own index.
// ----------------------------------------------------------------------------
module fbpa_stack_ram (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  fbpa_pkg::stack_req_t      req,
    output logic [fbpa_pkg::IDX_W-1:0] rd_idx
);
    import fbpa_pkg::*;

    logic [IDX_W-1:0]      mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg;
    logic [IDX_W-1:0]      rd_data_reg;
    logic [IDX_W-1:0]      rd_addr_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg  <= mem[req.rd_addr];
            rd_addr_reg  <= req.rd_addr;
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rd_idx = rd_valid_reg ? rd_data_reg : rd_addr_reg;

endmodule

// File: hw/rtl/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Operation sequencer: stack pointer, free map and result register.
// Reads the stack top on accept, resolves the operation in the execute state once the output is free.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [fbpa_pkg::OPCODE_W-1:0]   opcode,
    input  logic [fbpa_pkg::OFF_IN_W-1:0]   byte_offset,
    input  logic [fbpa_pkg::SIZE_W-1:0]     elem_size,
    input  logic [fbpa_pkg::SIZE_W-1:0]     elem_count,
    output fbpa_pkg::stack_req_t            stack_req,
    input  logic [fbpa_pkg::IDX_W-1:0]      stack_rd_idx,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [fbpa_pkg::STATUS_W-1:0]   status,
    output logic [fbpa_pkg::BOFF_W-1:0]     block_offset,
    output logic [fbpa_pkg::FCOUNT_W-1:0]   free_count
);
    import fbpa_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                  state_reg, state_next;
    logic [OPCODE_W-1:0]   op_reg;
    logic [OFF_IN_W-1:0]   off_reg;
    logic [SIZE_W-1:0]     esz_reg;
    logic [SIZE_W-1:0]     ecnt_reg;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic [NUM_BLOCKS-1:0] map_reg, map_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [BOFF_W-1:0]     boff_reg, boff_next;

    logic                  accept;
    logic                  do_exec;
    logic [2*SIZE_W-1:0]   req_bytes;
    logic [IDX_W-1:0]      pop_idx;
    logic [IDX_W-1:0]      free_idx;
    logic                  off_bad;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign do_exec  = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    assign req_bytes = esz_reg * ecnt_reg;
    assign pop_idx   = (32'(stack_rd_idx) >= NUM_BLOCKS) ? '0 : stack_rd_idx;
    assign free_idx  = off_reg[BLOCK_SHIFT +: IDX_W];
    assign off_bad   = (32'(off_reg) >= POOL_BYTES) || (off_reg[BLOCK_SHIFT-1:0] != '0);

    always_comb begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        map_next        = map_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        boff_next       = boff_reg;
        stack_req       = '0;
        // stack top is read on every accept, used only by allocations
        stack_req.rd_en   = accept;
        stack_req.rd_addr = IDX_W'(depth_reg - 1'b1);
        if (accept) begin
            state_next = ST_EXEC;
        end
        if (do_exec) begin
            state_next     = ST_IDLE;
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            boff_next      = '0;
            unique case (op_reg)
                OP_ALLOC, OP_ALLOC_CHECK: begin
                    priority if (op_reg == OP_ALLOC_CHECK && 32'(req_bytes) > BLOCK_BYTES) begin
                        status_next = ST_TOO_LARGE;
                    end else if (depth_reg == '0) begin
                        status_next = ST_EXHAUSTED;
                    end else begin
                        depth_next        = depth_reg - 1'b1;
                        map_next[pop_idx] = 1'b0;
                        boff_next         = BOFF_W'(32'(pop_idx) * BLOCK_BYTES);
                    end
                end
                OP_FREE: begin
                    priority if (off_bad) begin
                        status_next = ST_INVALID;
                    end else if (map_reg[free_idx]) begin
                        status_next = ST_DOUBLE;
                    end else begin
                        map_next[free_idx] = 1'b1;
                        // a full stack skips the push but still marks the block free
                        if (32'(depth_reg) < NUM_BLOCKS) begin
                            stack_req.wr_en   = 1'b1;
                            stack_req.wr_addr = IDX_W'(depth_reg);
                            stack_req.wr_data = free_idx;
                            depth_next        = depth_reg + 1'b1;
                        end
                    end
                end
                OP_REINIT: begin
                    stack_req.clear = 1'b1;
                    depth_next      = DEPTH_W'(NUM_BLOCKS);
                    map_next        = '1;
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            depth_reg     <= DEPTH_W'(NUM_BLOCKS);
            map_reg       <= '1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            map_reg       <= map_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= opcode;
            off_reg  <= byte_offset;
            esz_reg  <= elem_size;
            ecnt_reg <= elem_count;
        end
        status_reg <= status_next;
        boff_reg   <= boff_next;
    end

    logic [FCOUNT_W-1:0] fcount_reg;
    always_ff @(posedge aclk) begin
        if (do_exec) begin
            fcount_reg <= FCOUNT_W'(depth_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign block_offset = boff_reg;
    assign free_count   = fcount_reg;

endmodule

// File: hw/rtl/fixed_block_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Fixed-size block pool allocator over a LIFO stack of free block indices.
// ----------------------------------------------------------------------------
// result: the transfer is registered, resolved in the execute state, then the result is registered
// operations: a new one is accepted only in the idle state, after the registered read of
//   the free stack memory and the update step of the previous one
// reset: synchronous active-low aresetn; all 16 blocks free, stack pointer
//   full, stack entries read as their own index, no result pending
module fixed_block_pool_allocator_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // opcode[1:0], byte_offset[11:2], elem_size[19:12], elem_count[27:20], zero pad
    input  logic [fbpa_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[2:0], block_offset[11:3], free_count[16:12], zero pad
    output logic [fbpa_pkg::M_TDATA_W-1:0]   m_tdata
);
    import fbpa_pkg::*;

    stack_req_t          stack_req;
    logic [IDX_W-1:0]    stack_rd_idx;
    logic [STATUS_W-1:0] status;
    logic [BOFF_W-1:0]   block_offset;
    logic [FCOUNT_W-1:0] free_count;

    fbpa_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .opcode       (s_tdata[1:0]),
        .byte_offset  (s_tdata[11:2]),
        .elem_size    (s_tdata[19:12]),
        .elem_count   (s_tdata[27:20]),
        .stack_req    (stack_req),
        .stack_rd_idx (stack_rd_idx),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .status       (status),
        .block_offset (block_offset),
        .free_count   (free_count)
    );

    fbpa_stack_ram u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (stack_req),
        .rd_idx  (stack_rd_idx)
    );

    assign m_tdata = {(M_TDATA_W - STATUS_W - BOFF_W - FCOUNT_W)'(0),
                      free_count, block_offset, status};

endmodule

// File: hw/rtl/fbpa_checker.sv
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks of the pool allocator result stream.
// ----------------------------------------------------------------------------
module fbpa_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [fbpa_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fbpa_pkg::M_TDATA_W-1:0] m_tdata
);
    import fbpa_pkg::*;

    // a result only follows an accepted transfer
    a_result_after_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without input transfer");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[16:12]) <= NUM_BLOCKS))
        else $error("free count beyond pool size");

    // only a successful allocation carries a block offset
    a_offset_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != ST_OK) |-> (m_tdata[11:3] == '0))
        else $error("block offset on failed operation");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);
